FILE: sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Holds the sizes, the request and status codes, the cell operations and
// the packed word types of the input and result channels.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int VALUE_BITS  = 32;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

  typedef enum logic [2:0] {
    MODE_ADD_FRONT = 3'd0,
    MODE_ADD_REAR  = 3'd1,
    MODE_REM_FRONT = 3'd2,
    MODE_REM_REAR  = 3'd3,
    MODE_INS_AT    = 3'd4,
    MODE_REM_AT    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  position;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] removed_value;
    logic [1:0]  status;
    logic [4:0]  entry_count;
  } out_word_t;

  typedef logic [MAX_ENTRIES-1:0][VALUE_BITS-1:0] entry_vec_t;
  typedef cell_op_t [MAX_ENTRIES-1:0] cell_op_vec_t;

endpackage

FILE: sv/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one slot of the list
// Holds one entry and each cycle keeps it, loads the new value, or takes
// the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [VALUE_BITS-1:0] load_val,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic [VALUE_BITS-1:0] right_val,
  output logic [VALUE_BITS-1:0] val
);

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;

  always_comb begin
    unique case (op)
      CELL_HOLD:  val_nxt = val_r;
      CELL_LOAD:  val_nxt = load_val;
      CELL_LEFT:  val_nxt = left_val;
      CELL_RIGHT: val_nxt = right_val;
      default:    val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

FILE: sv/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl: request decode and entry count
// Checks each request against the count, steers every cell, picks the
// removed entry and forms the result word.
// ----------------------------------------------------------------------------
module ple_ctrl import ple_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  in_word_t              req,
  input  entry_vec_t            entries,
  output cell_op_vec_t          cell_op,
  output logic [VALUE_BITS-1:0] load_val,
  output out_word_t             res
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] count_after;
  logic [CMP_W-1:0] cnt_e;
  logic [CMP_W-1:0] pos_e;
  logic [CMP_W-1:0] idx;
  logic             full;
  logic             empty;
  logic             do_ins;
  logic             do_rem;
  status_t          status;

  assign cnt_e = CMP_W'(count_r);
  assign pos_e = CMP_W'(req.position);
  assign full  = (count_r == CNT_W'(MAX_ENTRIES));
  assign empty = (count_r == '0);

  always_comb begin
    do_ins = 1'b0;
    do_rem = 1'b0;
    idx    = '0;
    status = ST_OK;
    unique case (req.mode)
      MODE_ADD_FRONT: begin
        if (full) status = ST_FULL;
        else do_ins = 1'b1;
      end
      MODE_ADD_REAR: begin
        idx = cnt_e;
        if (full) status = ST_FULL;
        else do_ins = 1'b1;
      end
      MODE_REM_FRONT: begin
        if (empty) status = ST_EMPTY;
        else do_rem = 1'b1;
      end
      MODE_REM_REAR: begin
        idx = cnt_e - CMP_W'(1);
        if (empty) status = ST_EMPTY;
        else do_rem = 1'b1;
      end
      MODE_INS_AT: begin
        idx = pos_e - CMP_W'(1);
        if (pos_e == '0 || pos_e > cnt_e + CMP_W'(1)) status = ST_RANGE;
        else if (full) status = ST_FULL;
        else do_ins = 1'b1;
      end
      MODE_REM_AT: begin
        idx = pos_e - CMP_W'(1);
        if (pos_e == '0 || pos_e > cnt_e) status = ST_RANGE;
        else do_rem = 1'b1;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cell_op[i] = CELL_HOLD;
      if (fire && do_ins) begin
        if (CMP_W'(i) == idx) cell_op[i] = CELL_LOAD;
        else if (CMP_W'(i) > idx && CMP_W'(i) <= cnt_e) cell_op[i] = CELL_LEFT;
      end else if (fire && do_rem) begin
        if (CMP_W'(i) >= idx && CMP_W'(i) + CMP_W'(1) < cnt_e) cell_op[i] = CELL_RIGHT;
      end
    end
  end

  assign load_val = VALUE_BITS'(req.value);

  always_comb begin
    count_after = count_r;
    if (do_ins) count_after = count_r + CNT_W'(1);
    else if (do_rem) count_after = count_r - CNT_W'(1);
  end

  assign count_nxt = fire ? count_after : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    res.removed_value = do_rem ? 32'(entries[idx[IDX_W-1:0]]) : 32'd0;
    res.status        = status;
    res.entry_count   = 5'(count_after);
  end

endmodule

FILE: sv/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit: bounded list with indexed insert and remove
// Row of slot cells steered by a decode and count unit, with a two-word
// result buffer.
// ----------------------------------------------------------------------------
// Each accepted word is one request; its result word is registered into
// the output register, or into the skid register while the output stalls.
// One request completes per cycle while in_stall is low: every cell shifts
// toward its neighbor or loads the new value, and the decode and count
// update close in that same cycle. The result side holds up to two words,
// so in_stall rises only once a result waits in the output and skid registers.
module positional_list_engine_unit import ple_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic                  in_fire;
  entry_vec_t            entries;
  cell_op_vec_t          cell_op;
  logic [VALUE_BITS-1:0] load_val;
  out_word_t             res;

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_word_t out_word_r;
  logic      skid_valid_r;
  logic      skid_valid_nxt;
  out_word_t skid_word_r;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .req      (in_word),
    .entries  (entries),
    .cell_op  (cell_op),
    .load_val (load_val),
    .res      (res)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_val;
    logic [VALUE_BITS-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_left
      assign left_val = entries[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_right
      assign right_val = entries[i+1];
    end
    ple_cell u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .load_val  (load_val),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (entries[i])
    );
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt  = skid_valid_r || in_fire;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_word_r <= skid_valid_r ? skid_word_r : res;
    end else if (in_fire) begin
      skid_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: sv/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker: port-level checks of the positional list engine
// Watches both channels for held words, input stalls backed by a waiting
// result, and consistent empty and full status codes.
// ----------------------------------------------------------------------------
module ple_checker import ple_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word dropped or changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("input word dropped or changed while stalled");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result word waiting");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_EMPTY |->
      out_word.entry_count == 5'd0 && out_word.removed_value == 32'd0)
    else $error("underflow status with entries or a removed value");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_FULL |->
      out_word.entry_count == 5'(MAX_ENTRIES) && out_word.removed_value == 32'd0)
    else $error("full status on a list that is not full");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

FILE: tb/tb_positional_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit: self-checking bench of the list engine
// Drives directed and random requests with random gaps and result-side
// stalls, including one long stall that backs up the input. A scoreboard
// tracks the list contents, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_unit import ple_pkg::*; ();

  localparam int RANDOM_REQS   = 1920;
  localparam int QUIET_REQS    = 300;
  localparam int WATCHDOG_CYC  = 5000;
  localparam int LONG_HOLD_CYC = 250;

  class list_tracker;
    logic [VALUE_BITS-1:0] slots [MAX_ENTRIES];
    int unsigned fill;
    int unsigned errors;
    out_word_t pending_results[$];

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void put_slot(int unsigned idx, logic [31:0] v);
      for (int unsigned k = fill; k > idx; k--) slots[k] = slots[k-1];
      slots[idx] = v;
      fill++;
    endfunction

    function logic [31:0] take_slot(int unsigned idx);
      logic [31:0] v;
      v = slots[idx];
      for (int unsigned k = idx; k + 1 < fill; k++) slots[k] = slots[k+1];
      fill--;
      return v;
    endfunction

    function void note_request(in_word_t w);
      out_word_t r;
      r = '0;
      r.status = ST_OK;
      case (w.mode)
        MODE_ADD_FRONT, MODE_ADD_REAR: begin
          if (fill >= MAX_ENTRIES) r.status = ST_FULL;
          else put_slot((w.mode == MODE_ADD_FRONT) ? 0 : fill, w.value);
        end
        MODE_REM_FRONT, MODE_REM_REAR: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.removed_value = take_slot((w.mode == MODE_REM_FRONT) ? 0 : fill - 1);
        end
        MODE_INS_AT: begin
          if (w.position < 1 || w.position > fill + 1) r.status = ST_RANGE;
          else if (fill >= MAX_ENTRIES) r.status = ST_FULL;
          else put_slot(w.position - 1, w.value);
        end
        MODE_REM_AT: begin
          if (w.position < 1 || w.position > fill) r.status = ST_RANGE;
          else r.removed_value = take_slot(w.position - 1);
        end
        default: ;
      endcase
      r.entry_count = 5'(fill);
      pending_results.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: got %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending_results.pop_front();
      if (got.removed_value !== exp_w.removed_value) begin
        $display("%0t: removed_value mismatch: expected %h actual %h", $time,
                 exp_w.removed_value, got.removed_value);
        errors++;
      end
      if (got.status !== exp_w.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time,
                 exp_w.status, got.status);
        errors++;
      end
      if (got.entry_count !== exp_w.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d actual %0d", $time,
                 exp_w.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  list_tracker tracker;
  int unsigned accepted_reqs = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          done = 1'b0;

  positional_list_engine_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tracker.note_request(in_word);
        accepted_reqs++;
      end
      if (out_valid && !out_stall) tracker.check_result(out_word);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_CYC) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(input in_word_t w);
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_req(input mode_t m, input logic [7:0] pos, input logic [31:0] v);
    in_word_t w;
    w.mode = m;
    w.position = pos;
    w.value = v;
    send_word(w);
  endtask

  function automatic in_word_t pick_request(int unsigned fill, bit grow);
    in_word_t w;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    w.value = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hffff_ffff : $urandom;
    w.position = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      w.mode = 3'($urandom_range(6, 7));
    end else if (roll < (grow ? 70 : 30)) begin
      case ($urandom_range(0, 2))
        0: w.mode = MODE_ADD_FRONT;
        1: w.mode = MODE_ADD_REAR;
        default: w.mode = MODE_INS_AT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: w.mode = MODE_REM_FRONT;
        1: w.mode = MODE_REM_REAR;
        default: w.mode = MODE_REM_AT;
      endcase
    end
    if ($urandom_range(0, 99) < 85) begin
      if (w.mode == MODE_INS_AT) w.position = 8'($urandom_range(1, fill + 1));
      else if (w.mode == MODE_REM_AT) w.position = 8'($urandom_range(1, (fill == 0) ? 1 : fill));
    end
    return w;
  endfunction

  initial begin : result_sink
    bit long_hold_done;
    int unsigned stall_odds;
    long_hold_done = 1'b0;
    stall_odds = 3;
    wait (rst_n);
    @(posedge clk);
    while (!done) begin
      if ($urandom_range(0, 29) == 0) stall_odds = $urandom_range(0, 4);
      if (!long_hold_done && accepted_reqs >= 500) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYC) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!quiet && stall_odds != 0 && $urandom_range(1, 4) <= stall_odds - 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    out_stall <= 1'b0;
  end

  initial begin : stimulus
    int unsigned made;
    int unsigned gap_odds;
    bit grow;
    in_word_t w;
    tracker = new();
    made = 0;
    gap_odds = 4;
    grow = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(MODE_REM_FRONT, 8'd0, 32'h0);
    send_req(MODE_REM_REAR, 8'd0, 32'h0);
    send_req(MODE_REM_AT, 8'd1, 32'h0);
    send_req(MODE_INS_AT, 8'd0, 32'h1234_5678);
    send_req(MODE_INS_AT, 8'd2, 32'h1234_5678);
    send_word(in_word_t'{3'd6, 8'hff, 32'hffff_ffff});
    send_word(in_word_t'{3'd7, 8'h00, 32'h0});
    send_req(MODE_INS_AT, 8'd1, 32'hffff_ffff);
    send_req(MODE_ADD_FRONT, 8'd0, 32'h0);
    send_req(MODE_ADD_REAR, 8'hff, 32'ha5a5_a5a5);
    for (int i = 0; i < 13; i++) send_req(i[0] ? MODE_ADD_FRONT : MODE_INS_AT,
                                          8'(i + 2), $urandom);
    send_req(MODE_ADD_FRONT, 8'd0, 32'h5a5a_5a5a);
    send_req(MODE_ADD_REAR, 8'd0, 32'h5a5a_5a5a);
    send_req(MODE_INS_AT, 8'd17, 32'h5a5a_5a5a);
    send_req(MODE_INS_AT, 8'd18, 32'h5a5a_5a5a);
    send_req(MODE_REM_AT, 8'd17, 32'h0);
    send_req(MODE_REM_AT, 8'd16, 32'h0);
    send_req(MODE_REM_AT, 8'd0, 32'h0);
    send_req(MODE_REM_AT, 8'd255, 32'h0);
    send_req(MODE_REM_AT, 8'd7, 32'h0);
    send_req(MODE_REM_FRONT, 8'd0, 32'h0);
    send_req(MODE_REM_REAR, 8'd0, 32'h0);

    while (made < RANDOM_REQS) begin
      if ($urandom_range(0, 39) == 0) grow = !grow;
      if ($urandom_range(0, 99) == 0) gap_odds = $urandom_range(0, 8);
      if (made >= RANDOM_REQS - QUIET_REQS) quiet = 1'b1;
      w = pick_request(tracker.fill, grow);
      send_word(w);
      if (w.mode <= MODE_REM_AT) made++;
      if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    done = 1'b1;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
